// File: rtl/polyline_point_at_distance_unit_macros.svh
// Assertion macros used by the top level of the polyline point-at-distance RTL.
`ifndef POLYLINE_POINT_AT_DISTANCE_UNIT_MACROS_SVH
`define POLYLINE_POINT_AT_DISTANCE_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PPAD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PPAD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ppad_pkg.sv
// Shared constants, types and the arctangent table of the polyline point-at-distance block.
package ppad_pkg;

  localparam int CoordWidth   = 32;
  localparam int FracBits     = 16;
  localparam int CordicSteps  = 20;
  localparam int LenWidth     = 48;
  localparam int AngleWidth   = 19;
  localparam int DiffWidth    = CoordWidth + 1;
  localparam int ZWidth       = 35;
  localparam int AtanIdxWidth = 5;

  localparam logic signed [ZWidth-1:0] PiQ30 = 35'sd3373259426;

  typedef enum logic [1:0] {OpMove, OpLine, OpCurve, OpClose} op_e;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic        [DiffWidth-1:0]  seg_len_t;
  typedef logic signed [DiffWidth:0]    quot_t;
  typedef logic signed [AngleWidth-1:0] angle_t;

  // atan(2^-i) in Q2.30.
  function automatic logic [31:0] atan_q30(input logic [AtanIdxWidth-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      5'd24: v = 32'd64;
      5'd25: v = 32'd32;
      5'd26: v = 32'd16;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/ppad_sqrt.sv
// Segment length unit: squares the deltas, then takes the floor square root two bits a cycle.
module ppad_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ppad_pkg::diff_t   dx_i,
  input  ppad_pkg::diff_t   dy_i,
  output logic              done_o,
  output ppad_pkg::seg_len_t len_o
);
  import ppad_pkg::*;

  localparam int RootW = DiffWidth;
  localparam int RadW  = 2 * RootW;
  localparam int RemW  = RootW + 3;
  localparam int CntW  = $clog2(RootW);

  typedef enum logic [1:0] {SIdle, SSqX, SSqY, SRun} sphase_e;

  sphase_e          phase_q;
  logic [RootW-1:0] mx_q, my_q, mx, my, root_q;
  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q, rem_sh, trial;
  logic [CntW-1:0]  cnt_q;
  logic             ge;

  always_comb begin
    mx     = dx_i[DiffWidth-1] ? RootW'(-dx_i) : RootW'(dx_i);
    my     = dy_i[DiffWidth-1] ? RootW'(-dy_i) : RootW'(dy_i);
    rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= SIdle;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (phase_q)
        SIdle: begin
          if (start_i) begin
            mx_q    <= mx;
            my_q    <= my;
            root_q  <= '0;
            rem_q   <= '0;
            cnt_q   <= '0;
            phase_q <= SSqX;
          end
        end
        SSqX: begin
          rad_q   <= mx_q * mx_q;
          phase_q <= SSqY;
        end
        SSqY: begin
          rad_q   <= rad_q + my_q * my_q;
          phase_q <= SRun;
        end
        SRun: begin
          rem_q  <= ge ? rem_sh - trial : rem_sh;
          root_q <= {root_q[RootW-2:0], ge};
          rad_q  <= rad_q << 2;
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CntW'(RootW - 1)) begin
            done_o  <= 1'b1;
            phase_q <= SIdle;
          end
        end
        default: phase_q <= SIdle;
      endcase
    end
  end

  assign len_o = root_q;

endmodule

// File: rtl/ppad_cordic.sv
// Vectoring CORDIC unit: atan2 of a delta, one micro-rotation a cycle.
module ppad_cordic (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ppad_pkg::diff_t dx_i,
  input  ppad_pkg::diff_t dy_i,
  output logic            done_o,
  output ppad_pkg::angle_t angle_o
);
  import ppad_pkg::*;

  localparam int XyWidth  = DiffWidth + 3;
  localparam int RndShift = 30 - FracBits;
  localparam logic signed [ZWidth-1:0] RndHalf = ZWidth'(1) << (RndShift - 1);
  localparam logic signed [ZWidth-1:0] AngMax =
    {{(ZWidth - AngleWidth + 1){1'b0}}, {(AngleWidth - 1){1'b1}}};
  localparam logic signed [ZWidth-1:0] AngMin = ~AngMax;

  typedef enum logic [1:0] {CIdle, CRun, CRound} cphase_e;

  cphase_e                  phase_q;
  logic signed [XyWidth-1:0] x_q, y_q, x_d, y_d, xs, ys, dx_ext, dy_ext;
  logic signed [ZWidth-1:0]  z_q, z_d, atan_z, z_sum, z_rnd;
  logic [AtanIdxWidth-1:0]   i_q;
  logic                      zero_q;

  always_comb begin
    dx_ext = {{3{dx_i[DiffWidth-1]}}, dx_i};
    dy_ext = {{3{dy_i[DiffWidth-1]}}, dy_i};
    xs     = x_q >>> i_q;
    ys     = y_q >>> i_q;
    atan_z = {3'b000, atan_q30(i_q)};
    if (y_q > 0) begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + atan_z;
    end else begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - atan_z;
    end
    z_sum = z_q + RndHalf;
    z_rnd = z_sum >>> RndShift;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= CIdle;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (phase_q)
        CIdle: begin
          if (start_i) begin
            i_q    <= '0;
            zero_q <= (dx_i == '0) && (dy_i == '0);
            // A vector in the left half-plane is turned by pi first.
            if (dx_i[DiffWidth-1]) begin
              x_q <= -dx_ext;
              y_q <= -dy_ext;
              z_q <= dy_i[DiffWidth-1] ? -PiQ30 : PiQ30;
            end else begin
              x_q <= dx_ext;
              y_q <= dy_ext;
              z_q <= '0;
            end
            phase_q <= CRun;
          end
        end
        CRun: begin
          x_q <= x_d;
          y_q <= y_d;
          z_q <= z_d;
          i_q <= i_q + 1'b1;
          if (i_q == AtanIdxWidth'(CordicSteps - 1)) begin
            phase_q <= CRound;
          end
        end
        CRound: begin
          priority if (zero_q) begin
            angle_o <= '0;
          end else if (z_rnd > AngMax) begin
            angle_o <= AngMax[AngleWidth-1:0];
          end else if (z_rnd < AngMin) begin
            angle_o <= AngMin[AngleWidth-1:0];
          end else begin
            angle_o <= z_rnd[AngleWidth-1:0];
          end
          done_o  <= 1'b1;
          phase_q <= CIdle;
        end
        default: phase_q <= CIdle;
      endcase
    end
  end

endmodule

// File: rtl/ppad_div.sv
// Scaled division unit: trunc(a * b / d) by one multiply and a restoring divide, one bit a cycle.
module ppad_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  ppad_pkg::diff_t    a_i,
  input  ppad_pkg::quot_t    b_i,
  input  ppad_pkg::seg_len_t d_i,
  output logic               done_o,
  output ppad_pkg::quot_t    q_o
);
  import ppad_pkg::*;

  localparam int MagAW = DiffWidth;
  localparam int MagBW = DiffWidth + 1;
  localparam int ProdW = MagAW + MagBW;
  localparam int RemW  = DiffWidth + 1;
  localparam int CntW  = $clog2(ProdW);

  typedef enum logic [1:0] {DIdle, DMul, DRun} dphase_e;

  dphase_e          phase_q;
  logic [MagAW-1:0] ma_q, ma;
  logic [MagBW-1:0] mb_q, mb;
  logic [DiffWidth-1:0] d_q;
  logic [ProdW-1:0] dq_q, dq_d;
  logic [RemW-1:0]  rem_q, rem_sh;
  logic [CntW-1:0]  cnt_q;
  logic             neg_q, ge;
  quot_t            quo;

  always_comb begin
    ma     = a_i[DiffWidth-1] ? MagAW'(-a_i) : MagAW'(a_i);
    mb     = b_i[DiffWidth] ? MagBW'(-b_i) : MagBW'(b_i);
    rem_sh = {rem_q[RemW-2:0], dq_q[ProdW-1]};
    ge     = rem_sh >= {1'b0, d_q};
    dq_d   = {dq_q[ProdW-2:0], ge};
    quo    = dq_d[DiffWidth:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= DIdle;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (phase_q)
        DIdle: begin
          if (start_i) begin
            ma_q    <= ma;
            mb_q    <= mb;
            d_q     <= d_i;
            neg_q   <= a_i[DiffWidth-1] ^ b_i[DiffWidth];
            phase_q <= DMul;
          end
        end
        DMul: begin
          dq_q    <= ma_q * mb_q;
          rem_q   <= '0;
          cnt_q   <= '0;
          phase_q <= DRun;
        end
        DRun: begin
          rem_q <= ge ? rem_sh - {1'b0, d_q} : rem_sh;
          dq_q  <= dq_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(ProdW - 1)) begin
            q_o     <= neg_q ? -quo : quo;
            done_o  <= 1'b1;
            phase_q <= DIdle;
          end
        end
        default: phase_q <= DIdle;
      endcase
    end
  end

endmodule

// File: rtl/polyline_point_at_distance_unit.sv
// Top level: command sequencer and path state of the polyline point-at-distance block.
//
// Input channel (s_axis): one path command per transfer. tuser carries the command
// (move, line, curve, close), tdata the end point and the two query offsets, and tlast
// marks the final command of a path. Output channel (m_axis): one transfer per path,
// sent after the command marked tlast, carrying total length, point, angle and found.
// Each command runs the length unit and the CORDIC unit side by side. The length unit
// squares both deltas, sums them and takes the root digit by digit, while the
// sequencer waits for both units. The command that reaches the query distance adds four
// scaled divisions on the division unit and a saturation step that clamps the point.
// The final command then waits in its own state to load the output register.
// The block takes one command at a time and is not ready while a command is in work.
// Reset clears the path state and empties the output register. A stalled receiver
// holds the result in the output register; the next path's commands are still taken,
// and only its final command waits for the register to be free.
`include "polyline_point_at_distance_unit_macros.svh"

module polyline_point_at_distance_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // end_x [31:0], end_y [63:32], offset_along [95:64], offset_normal [127:96]
  input  logic [127:0] s_axis_tdata_i,
  // op [1:0]
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // total_length [47:0], point_x [79:48], point_y [111:80], angle [130:112], zero pad
  output logic [135:0] m_axis_tdata_o,
  // found [0]
  output logic [0:0]   m_axis_tuser_o
);
  import ppad_pkg::*;

  localparam int HxW        = CoordWidth + 4;
  localparam int CmpW       = LenWidth + 2;
  localparam int OutFieldsW = LenWidth + 2 * CoordWidth + AngleWidth;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;
  localparam logic signed [HxW-1:0] CoordMax =
    {{(HxW - CoordWidth + 1){1'b0}}, {(CoordWidth - 1){1'b1}}};
  localparam logic signed [HxW-1:0] CoordMin = ~CoordMax;

  typedef enum logic [2:0] {TIdle, TUnits, TCheck, TDiv, TSat, TAcc, TOut} state_e;

  state_e              state_q;
  op_e                 in_op, op_q;
  coord_t              in_ex, in_ey, nx, ny;
  coord_t              off_q, offn_q, px_q, py_q;
  coord_t              sub_x_q, sub_y_q, cur_x_q, cur_y_q, hit_x_q, hit_y_q;
  diff_t               dx_q, dy_q, div_a;
  quot_t               t_q, div_b, div_q, offn_ext;
  seg_len_t            len_q, sqrt_len;
  angle_t              ang_q, cordic_ang;
  logic [LenWidth-1:0] acc_q;
  logic [LenWidth:0]   sum_len;
  logic signed [CmpW-1:0] reach_lhs, off_ext, t_full;
  logic signed [HxW-1:0]  hx_q, hy_q, q_ext;
  logic [1:0]          sel_q;
  logic                last_q, hit_q, reach;
  logic                sqrt_go_q, atan_go_q, div_go_q, sqrt_ok_q, atan_ok_q;
  logic                sqrt_done, atan_done, div_done;
  logic                m_valid_q;
  logic [OutDataW-1:0] m_tdata_q;
  logic                m_found_q;
  logic                out_load;

  function automatic coord_t sat_coord(input logic signed [HxW-1:0] v);
    coord_t r;
    priority if (v > CoordMax) begin
      r = CoordMax[CoordWidth-1:0];
    end else if (v < CoordMin) begin
      r = CoordMin[CoordWidth-1:0];
    end else begin
      r = v[CoordWidth-1:0];
    end
    return r;
  endfunction

  always_comb begin
    in_op = op_e'(s_axis_tuser_i);
    in_ex = s_axis_tdata_i[31:0];
    in_ey = s_axis_tdata_i[63:32];
    unique case (in_op)
      OpMove, OpLine: begin
        nx = in_ex;
        ny = in_ey;
      end
      OpClose: begin
        nx = sub_x_q;
        ny = sub_y_q;
      end
      OpCurve: begin
        nx = cur_x_q;
        ny = cur_y_q;
      end
    endcase

    sum_len   = {1'b0, acc_q} + {{(LenWidth - DiffWidth + 1){1'b0}}, len_q};
    reach_lhs = {1'b0, sum_len};
    off_ext   = {{(CmpW - CoordWidth){off_q[CoordWidth-1]}}, off_q};
    reach     = reach_lhs >= off_ext;
    t_full    = off_ext - {2'b00, acc_q};

    offn_ext = {{2{offn_q[CoordWidth-1]}}, offn_q};
    unique case (sel_q)
      2'd0: begin
        div_a = dx_q;
        div_b = t_q;
      end
      2'd1: begin
        div_a = -dy_q;
        div_b = offn_ext;
      end
      2'd2: begin
        div_a = dy_q;
        div_b = t_q;
      end
      default: begin
        div_a = dx_q;
        div_b = offn_ext;
      end
    endcase
    q_ext = {{(HxW - DiffWidth - 1){div_q[DiffWidth]}}, div_q};

    // The output register takes a new result when it is empty or being emptied.
    out_load = (state_q == TOut) && (!m_valid_q || m_axis_tready_i);
  end

  ppad_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_go_q),
    .dx_i    (dx_q),
    .dy_i    (dy_q),
    .done_o  (sqrt_done),
    .len_o   (sqrt_len)
  );

  ppad_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (atan_go_q),
    .dx_i    (dx_q),
    .dy_i    (dy_q),
    .done_o  (atan_done),
    .angle_o (cordic_ang)
  );

  ppad_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .a_i     (div_a),
    .b_i     (div_b),
    .d_i     (len_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= TIdle;
      sqrt_go_q <= 1'b0;
      atan_go_q <= 1'b0;
      div_go_q  <= 1'b0;
      sqrt_ok_q <= 1'b0;
      atan_ok_q <= 1'b0;
      m_valid_q <= 1'b0;
      sub_x_q   <= '0;
      sub_y_q   <= '0;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      acc_q     <= '0;
      hit_q     <= 1'b0;
      hit_x_q   <= '0;
      hit_y_q   <= '0;
      ang_q     <= '0;
    end else begin
      sqrt_go_q <= 1'b0;
      atan_go_q <= 1'b0;
      div_go_q  <= 1'b0;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        TIdle: begin
          if (s_axis_tvalid_i) begin
            op_q      <= in_op;
            last_q    <= s_axis_tlast_i;
            off_q     <= s_axis_tdata_i[95:64];
            offn_q    <= s_axis_tdata_i[127:96];
            px_q      <= cur_x_q;
            py_q      <= cur_y_q;
            dx_q      <= {nx[CoordWidth-1], nx} - {cur_x_q[CoordWidth-1], cur_x_q};
            dy_q      <= {ny[CoordWidth-1], ny} - {cur_y_q[CoordWidth-1], cur_y_q};
            cur_x_q   <= nx;
            cur_y_q   <= ny;
            if (in_op == OpMove) begin
              sub_x_q <= in_ex;
              sub_y_q <= in_ey;
            end
            sqrt_go_q <= 1'b1;
            atan_go_q <= 1'b1;
            sqrt_ok_q <= 1'b0;
            atan_ok_q <= 1'b0;
            state_q   <= TUnits;
          end
        end
        TUnits: begin
          if (sqrt_done) begin
            // Only line and close commands contribute a length.
            len_q     <= (op_q == OpLine || op_q == OpClose) ? sqrt_len : '0;
            sqrt_ok_q <= 1'b1;
          end
          if (atan_done) begin
            if (!hit_q) begin
              ang_q <= cordic_ang;
            end
            atan_ok_q <= 1'b1;
          end
          if (sqrt_ok_q && atan_ok_q) begin
            state_q <= TCheck;
          end
        end
        TCheck: begin
          if (!hit_q && len_q != '0 && reach) begin
            t_q      <= t_full[DiffWidth:0];
            hx_q     <= {{(HxW - CoordWidth){px_q[CoordWidth-1]}}, px_q};
            hy_q     <= {{(HxW - CoordWidth){py_q[CoordWidth-1]}}, py_q};
            sel_q    <= '0;
            div_go_q <= 1'b1;
            state_q  <= TDiv;
          end else begin
            state_q <= TAcc;
          end
        end
        TDiv: begin
          if (div_done) begin
            if (!sel_q[1]) begin
              hx_q <= hx_q + q_ext;
            end else begin
              hy_q <= hy_q + q_ext;
            end
            if (&sel_q) begin
              state_q <= TSat;
            end else begin
              sel_q    <= sel_q + 1'b1;
              div_go_q <= 1'b1;
            end
          end
        end
        TSat: begin
          hit_x_q <= sat_coord(hx_q);
          hit_y_q <= sat_coord(hy_q);
          hit_q   <= 1'b1;
          state_q <= TAcc;
        end
        TAcc: begin
          acc_q   <= sum_len[LenWidth] ? '1 : sum_len[LenWidth-1:0];
          state_q <= last_q ? TOut : TIdle;
        end
        TOut: begin
          if (out_load) begin
            m_tdata_q <= {{(OutDataW - OutFieldsW){1'b0}}, ang_q,
                          hit_q ? hit_y_q : cur_y_q,
                          hit_q ? hit_x_q : cur_x_q, acc_q};
            m_found_q <= hit_q;
            sub_x_q   <= '0;
            sub_y_q   <= '0;
            cur_x_q   <= '0;
            cur_y_q   <= '0;
            acc_q     <= '0;
            hit_q     <= 1'b0;
            hit_x_q   <= '0;
            hit_y_q   <= '0;
            ang_q     <= '0;
            state_q   <= TIdle;
          end
        end
        default: state_q <= TIdle;
      endcase
    end
  end

  assign s_axis_tready_o   = (state_q == TIdle);
  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = m_tdata_q;
  assign m_axis_tuser_o[0] = m_found_q;

  `PPAD_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "block stayed ready after an accepted transfer")
  `PPAD_ASSERT_IMP(a_hit_clear_on_result, $fell(hit_q), m_valid_q, "hit cleared without a result being loaded")
  `PPAD_ASSERT_IMP(a_div_only_before_hit, div_go_q, state_q == TDiv && !hit_q, "division started outside the hit sequence")
  `PPAD_ASSERT_IMP(a_result_only_on_last, $rose(m_valid_q), $past(last_q), "result produced for a command not marked last")

endmodule

// File: tb/polyline_point_at_distance_unit_test.sv
// Self-checking testbench of the polyline point-at-distance block.
`timescale 1ns / 1ps

module polyline_point_at_distance_unit_test;
  import ppad_pkg::*;

  localparam longint unsigned LenMax = 64'hFFFF_FFFF_FFFF;
  localparam longint PiZ = 64'sd3373259426;

  typedef struct packed {
    logic [1:0]   op;
    logic [31:0]  end_x;
    logic [31:0]  end_y;
    logic [31:0]  off_along;
    logic [31:0]  off_normal;
    logic         last;
  } path_cmd_t;

  typedef struct packed {
    logic [47:0]  total_length;
    logic         found;
    logic [31:0]  point_x;
    logic [31:0]  point_y;
    logic [18:0]  angle;
  } path_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i;
  logic [1:0]   s_axis_tuser_i;
  logic         s_axis_tlast_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [135:0] m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;

  polyline_point_at_distance_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Path state of the predictor.
  longint          start_x, start_y, pos_x, pos_y;
  longint unsigned run_length;
  bit              hit_seen;
  longint          hit_px, hit_py, seg_angle;

  path_result_t    pending_results[$];
  int              error_count;
  int              cmds_sent;
  int              results_seen;
  int              hits_seen;
  bit              gaps_on;
  int              hold_cycles;

  longint atan_steps[20] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048};

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned root_of_squares(longint dx, longint dy);
    logic [127:0] sum, cand;
    longint unsigned root;
    root = 0;
    sum = 128'(magnitude(dx)) * 128'(magnitude(dx)) + 128'(magnitude(dy)) * 128'(magnitude(dy));
    for (int b = 40; b >= 0; b--) begin
      cand = 128'(root | (64'd1 << b));
      if (cand * cand <= sum) root = cand[63:0];
    end
    return root;
  endfunction

  // trunc(a * b / d), quotient kept to 62 bits; the block keeps a 34-bit signed quotient.
  function automatic longint scaled_quotient(longint a, longint b, longint unsigned d);
    logic [127:0] prod, quo;
    longint unsigned q;
    prod = 128'(magnitude(a)) * 128'(magnitude(b));
    quo = prod / 128'(d);
    q = quo[63:0] & 64'h3FFF_FFFF_FFFF_FFFF;
    return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint direction_angle(longint dy, longint dx);
    longint x, y, z, xs, ys, r;
    x = dx;
    y = dy;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PiZ : -PiZ;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_steps[i];
      end else begin
        x -= ys; y += xs; z -= atan_steps[i];
      end
    end
    r = (z + (64'sd1 <<< 13)) >>> 14;
    if (r > 262143) r = 262143;
    if (r < -262144) r = -262144;
    return r;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void clear_path();
    start_x = 0; start_y = 0; pos_x = 0; pos_y = 0;
    run_length = 0;
    hit_seen = 1'b0;
    hit_px = 0; hit_py = 0; seg_angle = 0;
  endfunction

  // Advances the path state by one command; returns 1 with the result on the final one.
  function automatic bit advance_path(input path_cmd_t c, output path_result_t res);
    longint ex, ey, off, offn, px, py, dx, dy, t;
    longint unsigned seg;
    ex = longint'(signed'(c.end_x));
    ey = longint'(signed'(c.end_y));
    off = longint'(signed'(c.off_along));
    offn = longint'(signed'(c.off_normal));
    px = pos_x;
    py = pos_y;
    seg = 0;
    res = '0;
    case (c.op)
      OpMove: begin
        start_x = ex; start_y = ey; pos_x = ex; pos_y = ey;
      end
      OpLine: begin
        seg = root_of_squares(ex - pos_x, ey - pos_y);
        pos_x = ex; pos_y = ey;
      end
      OpClose: begin
        seg = root_of_squares(start_x - pos_x, start_y - pos_y);
        pos_x = start_x; pos_y = start_y;
      end
      default: ;
    endcase
    dx = pos_x - px;
    dy = pos_y - py;
    if (!hit_seen) begin
      seg_angle = direction_angle(dy, dx);
      if (seg != 0 && longint'(run_length) + longint'(seg) >= off) begin
        t = off - longint'(run_length);
        hit_px = clamp_coord(px + scaled_quotient(dx, t, seg) + scaled_quotient(-dy, offn, seg));
        hit_py = clamp_coord(py + scaled_quotient(dy, t, seg) + scaled_quotient(dx, offn, seg));
        hit_seen = 1'b1;
      end
    end
    run_length = (LenMax - run_length < seg) ? LenMax : run_length + seg;
    if (!c.last) return 1'b0;
    res.total_length = run_length[47:0];
    res.found = hit_seen;
    res.point_x = hit_seen ? hit_px[31:0] : pos_x[31:0];
    res.point_y = hit_seen ? hit_py[31:0] : pos_y[31:0];
    res.angle = seg_angle[18:0];
    clear_path();
    return 1'b1;
  endfunction

  // Offers one command, idling first at random, and predicts once the transfer happens.
  task automatic send_command(input path_cmd_t c);
    path_result_t res;
    if (gaps_on && $urandom_range(99) < 13) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 13);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {c.off_normal, c.off_along, c.end_y, c.end_x};
    s_axis_tuser_i  <= c.op;
    s_axis_tlast_i  <= c.last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    cmds_sent++;
    if (advance_path(c, res)) pending_results.push_back(res);
  endtask

  task automatic stop_sending();
    s_axis_tvalid_i <= 1'b0;
  endtask

  function automatic path_cmd_t make_cmd(logic [1:0] op, longint x, longint y,
                                         longint off, longint offn, bit last);
    path_cmd_t c;
    c.op = op;
    c.end_x = x[31:0];
    c.end_y = y[31:0];
    c.off_along = off[31:0];
    c.off_normal = offn[31:0];
    c.last = last;
    return c;
  endfunction

  function automatic longint scaled_value(int shift);
    return longint'(signed'($urandom)) >>> shift;
  endfunction

  // Random path: mostly a move followed by lines and closes; some items are pure noise.
  task automatic send_random_path();
    int n, shift;
    longint off, offn;
    path_cmd_t c;
    logic [1:0] op;
    n = $urandom_range(1, 8);
    shift = ($urandom_range(9) == 0) ? 0 : $urandom_range(4, 24);
    off = scaled_value(shift) + (longint'(n) << (31 - shift));
    if ($urandom_range(5) == 0) off = scaled_value(shift);
    offn = scaled_value($urandom_range(3) == 0 ? 0 : shift);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) begin
        c = make_cmd(2'($urandom), longint'($urandom), longint'($urandom),
                     longint'($urandom), longint'($urandom), i == n - 1);
      end else begin
        op = (i == 0) ? OpMove : ($urandom_range(9) == 0 ? OpClose :
             ($urandom_range(19) == 0 ? OpCurve : OpLine));
        if (i > 0 && $urandom_range(29) == 0) op = OpMove;
        c = make_cmd(op, scaled_value(shift), scaled_value(shift), off, offn, i == n - 1);
        // Repeat the current point now and then to give zero-length segments.
        if (op == OpLine && $urandom_range(19) == 0) begin
          c.end_x = pos_x[31:0];
          c.end_y = pos_y[31:0];
        end
      end
      send_command(c);
    end
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    stop_sending();
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (400) @(posedge clk_i);
  endtask

  task automatic test_directed();
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    // Unit square, query half way round with a left offset.
    send_command(make_cmd(OpMove, 0, 0, 64'sd131072, 64'sd16384, 1'b0));
    send_command(make_cmd(OpLine, 64'sd65536, 0, 64'sd131072, 64'sd16384, 1'b0));
    send_command(make_cmd(OpLine, 64'sd65536, 64'sd65536, 64'sd131072, 64'sd16384, 1'b0));
    send_command(make_cmd(OpCurve, mx, mn, 64'sd131072, 64'sd16384, 1'b0));
    send_command(make_cmd(OpLine, 0, 64'sd65536, 64'sd131072, 64'sd16384, 1'b0));
    send_command(make_cmd(OpClose, mx, mx, 64'sd131072, 64'sd16384, 1'b1));
    // Query beyond the path: nothing found, angle of the last command.
    send_command(make_cmd(OpMove, -64'sd65536, 64'sd65536, mx, 0, 1'b0));
    send_command(make_cmd(OpLine, 64'sd65536, -64'sd65536, mx, 0, 1'b1));
    // Diagonal across the full range with extreme offsets, changing within the path.
    send_command(make_cmd(OpMove, mn, mn, mn, mx, 1'b0));
    send_command(make_cmd(OpLine, mx, mx, mn, mx, 1'b0));
    send_command(make_cmd(OpLine, mn, mx, 0, mn, 1'b0));
    send_command(make_cmd(OpClose, 0, 0, mx, mn, 1'b1));
    // Zero-length line and a path ending in a move, a lone close and a lone curve.
    send_command(make_cmd(OpMove, 64'sd100, 64'sd200, 0, 0, 1'b0));
    send_command(make_cmd(OpLine, 64'sd100, 64'sd200, 0, 0, 1'b0));
    send_command(make_cmd(OpMove, -64'sd5000, 64'sd7000, 0, 0, 1'b1));
    send_command(make_cmd(OpClose, 0, 0, 0, 0, 1'b1));
    send_command(make_cmd(OpCurve, mx, mx, 0, 0, 1'b1));
    // Negative query with no leading move: extrapolated backwards.
    send_command(make_cmd(OpLine, 0, -64'sd65536, mn, mx, 1'b0));
    send_command(make_cmd(OpLine, mn, 0, mn, mx, 1'b1));
    drain_results();
  endtask

  task automatic test_random_paths();
    int start;
    start = cmds_sent;
    while (cmds_sent - start < 1100) begin
      // A long calm stretch with no idling on either side.
      gaps_on = !((cmds_sent - start) > 400 && (cmds_sent - start) < 600);
      send_random_path();
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  task automatic test_output_stall();
    hold_cycles = 3000;
    for (int i = 0; i < 12; i++) send_random_path();
    drain_results();
  endtask

  // Receiver: random stalls, a calm stretch, and a long hold-off when asked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !gaps_on || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk_i) begin
    path_result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.total_length = m_axis_tdata_o[47:0];
      got.point_x = m_axis_tdata_o[79:48];
      got.point_y = m_axis_tdata_o[111:80];
      got.angle = m_axis_tdata_o[130:112];
      got.found = m_axis_tuser_o[0];
      results_seen++;
      if (got.found) hits_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.total_length !== want.total_length) begin
          $display("%0t: total_length expected %h actual %h", $time,
                   want.total_length, got.total_length);
          error_count++;
        end
        if (got.found !== want.found) begin
          $display("%0t: found expected %b actual %b", $time, want.found, got.found);
          error_count++;
        end
        if (got.point_x !== want.point_x) begin
          $display("%0t: point_x expected %h actual %h", $time, want.point_x, got.point_x);
          error_count++;
        end
        if (got.point_y !== want.point_y) begin
          $display("%0t: point_y expected %h actual %h", $time, want.point_y, got.point_y);
          error_count++;
        end
        if (got.angle !== want.angle) begin
          $display("%0t: angle expected %h actual %h", $time, want.angle, got.angle);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = OpMove;
    s_axis_tlast_i = 1'b0;
    error_count = 0;
    cmds_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    gaps_on = 1'b1;
    hold_cycles = 0;
    clear_path();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_paths();
    test_output_stall();

    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    $display("Sent %0d path commands and checked %0d path results (%0d with a hit),",
             cmds_sent, results_seen, hits_seen);
    $display("including extreme coordinates, random idling and a long output stall.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
